@@ rtl/qrm_pkg.sv @@
package qrm_pkg;

    localparam int CW = 16;
    localparam int PW = 2 * CW;
    localparam int NW = PW + 1;
    localparam int SW = PW + 3;
    localparam int RW = NW + 1;
    localparam int QW = 16;
    localparam int OW = 16;
    localparam int NE = 9;
    localparam logic [OW-1:0] ONE_Q14 = OW'(16384);

    localparam int E_XX = 0;
    localparam int E_YX = 1;
    localparam int E_ZX = 2;
    localparam int E_XY = 3;
    localparam int E_YY = 4;
    localparam int E_ZY = 5;
    localparam int E_XZ = 6;
    localparam int E_YZ = 7;
    localparam int E_ZZ = 8;

    typedef struct packed {
        logic signed [CW-1:0] quat_w;
        logic signed [CW-1:0] quat_x;
        logic signed [CW-1:0] quat_y;
        logic signed [CW-1:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [OW-1:0] m_xx;
        logic signed [OW-1:0] m_yx;
        logic signed [OW-1:0] m_zx;
        logic signed [OW-1:0] m_xy;
        logic signed [OW-1:0] m_yy;
        logic signed [OW-1:0] m_zy;
        logic signed [OW-1:0] m_xz;
        logic signed [OW-1:0] m_yz;
        logic signed [OW-1:0] m_zz;
        logic              zero_length;
    } t_result;

    typedef struct packed {
        logic signed [PW-1:0] ww;
        logic signed [PW-1:0] xx;
        logic signed [PW-1:0] yy;
        logic signed [PW-1:0] zz;
        logic signed [PW-1:0] xy;
        logic signed [PW-1:0] wz;
        logic signed [PW-1:0] xz;
        logic signed [PW-1:0] wy;
        logic signed [PW-1:0] yz;
        logic signed [PW-1:0] wx;
    } t_prod;

    typedef struct packed {
        logic [NE-1:0][RW-1:0] rem;
        logic [NE-1:0][QW-1:0] quo;
        logic [NE-1:0]         neg;
        logic [NW-1:0]         den;
        logic                  zero;
    } t_div;

endpackage

@@ rtl/quaternion_to_rotation_matrix.sv @@
// Pipeline from start to o_valid: products, sums, 16 divider steps, rounding.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Each of the 16 quotient bits is one compare-subtract stage for all nine elements.
// Reset: synchronous, active low; clears all stage valid bits, data is not reset.
// Results appear on o_result for one cycle with o_valid; the receiver cannot stall.
module quaternion_to_rotation_matrix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  qrm_pkg::t_quat       i_quat,
    output logic                 o_valid,
    output qrm_pkg::t_result     o_result
);

    logic                 prod_valid;
    qrm_pkg::t_prod       prod;
    logic                 div_valid [qrm_pkg::QW+1];
    qrm_pkg::t_div        div       [qrm_pkg::QW+1];

    assign busy = 1'b0;

    qrm_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_quat  (i_quat),
        .o_valid (prod_valid),
        .o_prod  (prod)
    );

    qrm_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .i_prod  (prod),
        .o_valid (div_valid[0]),
        .o_div   (div[0])
    );

    for (genvar s = 0; s < qrm_pkg::QW; s++) begin : g_div
        qrm_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[s]),
            .i_div   (div[s]),
            .o_valid (div_valid[s+1]),
            .o_div   (div[s+1])
        );
    end

    qrm_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid[qrm_pkg::QW]),
        .i_div    (div[qrm_pkg::QW]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

@@ rtl/qrm_products.sv @@
module qrm_products (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  qrm_pkg::t_quat       i_quat,
    output logic                 o_valid,
    output qrm_pkg::t_prod       o_prod
);

    logic           r_valid;
    qrm_pkg::t_prod r_prod;
    qrm_pkg::t_prod n_prod;

    always_comb begin
        n_prod.ww = i_quat.quat_w * i_quat.quat_w;
        n_prod.xx = i_quat.quat_x * i_quat.quat_x;
        n_prod.yy = i_quat.quat_y * i_quat.quat_y;
        n_prod.zz = i_quat.quat_z * i_quat.quat_z;
        n_prod.xy = i_quat.quat_x * i_quat.quat_y;
        n_prod.wz = i_quat.quat_w * i_quat.quat_z;
        n_prod.xz = i_quat.quat_x * i_quat.quat_z;
        n_prod.wy = i_quat.quat_w * i_quat.quat_y;
        n_prod.yz = i_quat.quat_y * i_quat.quat_z;
        n_prod.wx = i_quat.quat_w * i_quat.quat_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_prod <= n_prod;
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

@@ rtl/qrm_numer.sv @@
module qrm_numer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  qrm_pkg::t_prod       i_prod,
    output logic                 o_valid,
    output qrm_pkg::t_div        o_div
);

    logic                        r_valid;
    qrm_pkg::t_div               r_div;
    qrm_pkg::t_div               n_div;
    logic signed [qrm_pkg::SW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    logic signed [qrm_pkg::SW-1:0] nrm;
    logic signed [qrm_pkg::SW-1:0] num [qrm_pkg::NE];
    logic signed [qrm_pkg::SW-1:0] mag;

    function automatic logic signed [qrm_pkg::SW-1:0] ext(
        input logic signed [qrm_pkg::PW-1:0] p
    );
        return {{(qrm_pkg::SW - qrm_pkg::PW){p[qrm_pkg::PW-1]}}, p};
    endfunction

    always_comb begin
        ww = ext(i_prod.ww);
        xx = ext(i_prod.xx);
        yy = ext(i_prod.yy);
        zz = ext(i_prod.zz);
        xy = ext(i_prod.xy);
        wz = ext(i_prod.wz);
        xz = ext(i_prod.xz);
        wy = ext(i_prod.wy);
        yz = ext(i_prod.yz);
        wx = ext(i_prod.wx);
        nrm = ww + xx + yy + zz;
        num[qrm_pkg::E_XX] = ww + xx - yy - zz;
        num[qrm_pkg::E_YX] = (xy + wz) <<< 1;
        num[qrm_pkg::E_ZX] = (xz - wy) <<< 1;
        num[qrm_pkg::E_XY] = (xy - wz) <<< 1;
        num[qrm_pkg::E_YY] = ww + yy - xx - zz;
        num[qrm_pkg::E_ZY] = (yz + wx) <<< 1;
        num[qrm_pkg::E_XZ] = (xz + wy) <<< 1;
        num[qrm_pkg::E_YZ] = (yz - wx) <<< 1;
        num[qrm_pkg::E_ZZ] = ww + zz - xx - yy;
        n_div.den  = nrm[qrm_pkg::NW-1:0];
        n_div.zero = (nrm == '0);
        mag        = '0;
        for (int e = 0; e < qrm_pkg::NE; e++) begin
            n_div.neg[e] = num[e][qrm_pkg::SW-1];
            mag          = num[e][qrm_pkg::SW-1] ? -num[e] : num[e];
            n_div.rem[e] = mag[qrm_pkg::RW-1:0];
            n_div.quo[e] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_div <= n_div;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

@@ rtl/qrm_div_step.sv @@
module qrm_div_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  qrm_pkg::t_div        i_div,
    output logic                 o_valid,
    output qrm_pkg::t_div        o_div
);

    logic                      r_valid;
    qrm_pkg::t_div             r_div;
    qrm_pkg::t_div             n_div;
    logic [qrm_pkg::RW-1:0]    den;
    logic [qrm_pkg::RW-1:0]    dif;
    logic                      ge;

    // one restoring step per element; remainder leaves pre-shifted
    always_comb begin
        n_div = i_div;
        den   = {1'b0, i_div.den};
        dif   = '0;
        ge    = 1'b0;
        for (int e = 0; e < qrm_pkg::NE; e++) begin
            ge           = (i_div.rem[e] >= den);
            dif          = ge ? (i_div.rem[e] - den) : i_div.rem[e];
            n_div.rem[e] = {dif[qrm_pkg::RW-2:0], 1'b0};
            n_div.quo[e] = {i_div.quo[e][qrm_pkg::QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_div <= n_div;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

@@ rtl/qrm_round.sv @@
module qrm_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  qrm_pkg::t_div        i_div,
    output logic                 o_valid,
    output qrm_pkg::t_result     o_result
);

    logic                      r_valid;
    qrm_pkg::t_result          r_result;
    qrm_pkg::t_result          n_result;
    logic [qrm_pkg::OW-1:0]    elem [qrm_pkg::NE];
    logic [qrm_pkg::QW:0]      qr;
    logic [qrm_pkg::OW-1:0]    mag;

    always_comb begin
        qr  = '0;
        mag = '0;
        for (int e = 0; e < qrm_pkg::NE; e++) begin
            qr  = {1'b0, i_div.quo[e]} + 1'b1;
            mag = qrm_pkg::OW'(qr[qrm_pkg::QW:1]);
            if (mag > qrm_pkg::ONE_Q14) begin
                mag = qrm_pkg::ONE_Q14;
            end
            elem[e] = i_div.neg[e] ? -mag : mag;
        end
        if (i_div.zero) begin
            for (int e = 0; e < qrm_pkg::NE; e++) begin
                elem[e] = '0;
            end
            elem[qrm_pkg::E_XX] = qrm_pkg::ONE_Q14;
            elem[qrm_pkg::E_YY] = qrm_pkg::ONE_Q14;
            elem[qrm_pkg::E_ZZ] = qrm_pkg::ONE_Q14;
        end
        n_result.m_xx        = elem[qrm_pkg::E_XX];
        n_result.m_yx        = elem[qrm_pkg::E_YX];
        n_result.m_zx        = elem[qrm_pkg::E_ZX];
        n_result.m_xy        = elem[qrm_pkg::E_XY];
        n_result.m_yy        = elem[qrm_pkg::E_YY];
        n_result.m_zy        = elem[qrm_pkg::E_ZY];
        n_result.m_xz        = elem[qrm_pkg::E_XZ];
        n_result.m_yz        = elem[qrm_pkg::E_YZ];
        n_result.m_zz        = elem[qrm_pkg::E_ZZ];
        n_result.zero_length = i_div.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
